/* src/tpt_pkg.sv */
// Shared types and constants for the transposition table probe/store block.
// No dependencies; imported by every module of the block except tpt_ram.
`default_nettype none

package tpt_pkg;

    localparam int TABLE_BITS_DEFAULT = 16;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int INDEX_BITS_W = 5;

    localparam logic REG_TABLE_ENABLE = 1'b0;
    localparam logic REG_INDEX_BITS   = 1'b1;

    localparam logic                    ENABLE_RESET     = 1'b1;
    localparam logic [INDEX_BITS_W-1:0] INDEX_BITS_RESET = 5'd16;

    localparam logic REQ_PROBE = 1'b0;
    localparam logic REQ_STORE = 1'b1;

    localparam int FLAG_BELOW_ALPHA = 0;
    localparam int FLAG_ABOVE_BETA  = 1;

    typedef struct packed {
        logic                    enable;
        logic [INDEX_BITS_W-1:0] index_bits;
    } cfg_t;

    typedef struct packed {
        logic        valid;
        logic [15:0] score;
        logic [1:0]  flags;
        logic [7:0]  depth;
        logic [31:0] key;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

/* src/tpt_ram.sv */
// Generic single-port synchronous RAM, registered read, read-before-write.
// No dependencies.
`default_nettype none

module tpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

/* src/tpt_regs.sv */
// APB configuration registers: table enable and index width.
// Depends on tpt_pkg.
`default_nettype none

module tpt_regs (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [tpt_pkg::CFG_ADDR_W-1:0]     paddr,
    input  wire logic [tpt_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic      [tpt_pkg::CFG_DATA_W-1:0]     prdata,
    output tpt_pkg::cfg_t                           cfg
);
    import tpt_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic wr_en;

    assign wr_en = psel && penable && pwrite;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (paddr[2])
                REG_TABLE_ENABLE: cfg_next.enable     = pwdata[0];
                REG_INDEX_BITS:   cfg_next.index_bits = pwdata[INDEX_BITS_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable     <= ENABLE_RESET;
            cfg_reg.index_bits <= INDEX_BITS_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        case (paddr[2])
            REG_TABLE_ENABLE: prdata[0] = cfg_reg.enable;
            REG_INDEX_BITS:   prdata[INDEX_BITS_W-1:0] = cfg_reg.index_bits;
            default:          prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

/* src/tpt_match.sv */
// Probe hit check of one stored entry against key, depth and alpha/beta window.
// Depends on tpt_pkg.
`default_nettype none

module tpt_match (
    input  wire tpt_pkg::entry_t entry,
    input  wire logic          enable,
    input  wire logic [31:0]   check_key,
    input  wire logic [7:0]    depth,
    input  wire logic signed [15:0] alpha,
    input  wire logic signed [15:0] beta,
    output logic               hit,
    output logic signed [15:0] found_score
);
    import tpt_pkg::*;

    logic signed [15:0] e_score;
    logic               above_ok;
    logic               below_ok;

    assign e_score  = $signed(entry.score);
    assign above_ok = entry.flags[FLAG_ABOVE_BETA] || (e_score >= beta);
    assign below_ok = entry.flags[FLAG_BELOW_ALPHA] || (e_score <= alpha);

    assign hit = enable && entry.valid && (entry.key == check_key)
                 && (entry.depth >= depth) && above_ok && below_ok;
    assign found_score = hit ? e_score : 16'sd0;

endmodule

`default_nettype wire

/* src/transposition_table_probe_store.sv */
// Top level: direct-mapped always-replace transposition table.
// Depends on tpt_pkg, tpt_regs, tpt_ram, tpt_match.
//
// Usage:
//   Input channel (in_valid/in_ready) carries a probe or a store request.
//   Output channel (out_valid/out_ready) returns exactly one result per
//   request: hit and found_score (both zero for a store or a miss).
//   A store writes the table on the transfer edge, and its result is
//   registered and visible in the next cycle.
//   A probe reads the slot through the single table port; the entry
//   returns in the next cycle and is checked into the output register.
//   One store per cycle while results are taken; a lookup stalls input.
//   After reset the block sweeps all 2**TABLE_BITS slots, one per cycle,
//   to clear their valid bits; in_ready stays low until the sweep ends.
//   Configuration writes over APB are taken at any time.
//   A result waiting in the output register does not block a new request
//   when it is taken in the same cycle; otherwise in_ready drops until
//   the receiver takes the result.
`default_nettype none

module transposition_table_probe_store #(
    parameter int TABLE_BITS = tpt_pkg::TABLE_BITS_DEFAULT
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [tpt_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [tpt_pkg::CFG_DATA_W-1:0] pwdata,
    output logic      [tpt_pkg::CFG_DATA_W-1:0] prdata,
    output logic                                pready,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic                           req_type,
    input  wire logic [31:0]                    index_hash,
    input  wire logic [31:0]                    check_key,
    input  wire logic [7:0]                     depth,
    input  wire logic signed [15:0]             alpha,
    input  wire logic signed [15:0]             beta,
    input  wire logic [1:0]                     bound_flags,
    input  wire logic signed [15:0]             store_score,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic                                hit,
    output logic signed [15:0]                  found_score
);
    import tpt_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR  = 3'b001,
        ST_IDLE   = 3'b010,
        ST_LOOKUP = 3'b100
    } state_t;

    state_t state_reg, state_next;
    cfg_t   cfg;

    logic [TABLE_BITS-1:0] clr_cnt_reg, clr_cnt_next;
    logic [TABLE_BITS-1:0] mask;
    logic [TABLE_BITS-1:0] slot;

    logic                ram_we;
    logic [TABLE_BITS-1:0] ram_addr;
    entry_t              ram_wdata;
    logic [ENTRY_W-1:0]  ram_rdata;
    entry_t              new_entry;

    logic               en_reg;
    logic [31:0]        key_reg;
    logic [7:0]         depth_reg;
    logic signed [15:0] alpha_reg;
    logic signed [15:0] beta_reg;

    logic               m_hit;
    logic signed [15:0] m_score;

    logic               out_valid_reg, out_valid_next;
    logic               hit_reg;
    logic signed [15:0] score_reg;

    logic in_xfer;
    logic load_store;
    logic load_probe;

    assign pready = 1'b1;

    tpt_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    always_comb
    begin
        for (int i = 0; i < TABLE_BITS; i++)
        begin
            mask[i] = (INDEX_BITS_W'(i) < cfg.index_bits);
        end
    end

    assign slot = index_hash[TABLE_BITS-1:0] & mask;

    assign in_ready   = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign in_xfer    = in_valid && in_ready;
    assign load_store = in_xfer && (req_type == REQ_STORE);
    assign load_probe = (state_reg == ST_LOOKUP);

    always_comb
    begin
        new_entry.valid = 1'b1;
        new_entry.score = store_score;
        new_entry.flags = bound_flags;
        new_entry.depth = depth;
        new_entry.key   = check_key;
    end

    always_comb
    begin
        if (state_reg == ST_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_addr  = clr_cnt_reg;
            ram_wdata = '0;
        end
        else
        begin
            ram_we    = load_store && cfg.enable;
            ram_addr  = slot;
            ram_wdata = new_entry;
        end
    end

    tpt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (2 ** TABLE_BITS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    tpt_match u_match (
        .entry       (entry_t'(ram_rdata)),
        .enable      (en_reg),
        .check_key   (key_reg),
        .depth       (depth_reg),
        .alpha       (alpha_reg),
        .beta        (beta_reg),
        .hit         (m_hit),
        .found_score (m_score)
    );

    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (&clr_cnt_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_xfer && (req_type == REQ_PROBE))
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_store || load_probe)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // probe payload held for the cycle the entry comes back
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            en_reg    <= cfg.enable;
            key_reg   <= check_key;
            depth_reg <= depth;
            alpha_reg <= alpha;
            beta_reg  <= beta;
        end
        if (load_store)
        begin
            hit_reg   <= 1'b0;
            score_reg <= 16'sd0;
        end
        else if (load_probe)
        begin
            hit_reg   <= m_hit;
            score_reg <= m_score;
        end
    end

    assign out_valid   = out_valid_reg;
    assign hit         = hit_reg;
    assign found_score = score_reg;

endmodule

`default_nettype wire

/* src/tpt_checker.sv */
// Port-level checker for transposition_table_probe_store, with its bind.
// Depends on tpt_pkg.
`default_nettype none

module tpt_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        req_type,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic        hit,
    input wire logic [15:0] found_score
);
    import tpt_pkg::*;

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !hit) |-> (found_score == 16'd0))
        else $error("miss with nonzero score");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(hit) && $stable(found_score)))
        else $error("stalled result changed");

    a_store_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (req_type == REQ_STORE)) |=> (out_valid && !hit))
        else $error("store result missing or hit");

    a_probe_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (req_type == REQ_PROBE)) |=> (!out_valid ##1 out_valid))
        else $error("probe result latency wrong");

endmodule

bind transposition_table_probe_store tpt_checker u_tpt_checker (.*);

`default_nettype wire

/* verif/transposition_table_probe_store_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for transposition_table_probe_store: probes and stores with a
// shadow table predicting every hit and score, APB register writes with readback checks.
// Depends on tpt_pkg and the block's RTL only.

module transposition_table_probe_store_tb;

    import tpt_pkg::*;

    localparam int TBITS = TABLE_BITS_DEFAULT;
    localparam longint RUN_LIMIT_NS = 64'd18_000_000;

    typedef struct {
        logic               kind;
        logic [31:0]        hash;
        logic [31:0]        key;
        logic [7:0]         depth;
        logic signed [15:0] alpha;
        logic signed [15:0] beta;
        logic [1:0]         flags;
        logic signed [15:0] score;
    } tt_req_t;

    typedef struct {
        logic               hit;
        logic signed [15:0] score;
    } tt_answer_t;

    class tt_shadow_table;
        logic                    enable;
        logic [INDEX_BITS_W-1:0] idx_bits;
        entry_t                  slot_mem[int unsigned];
        tt_answer_t              awaited[$];
        int                      mismatches;
        int                      probes;
        int                      stores;
        int                      hits;

        function new();
            enable     = ENABLE_RESET;
            idx_bits   = INDEX_BITS_RESET;
            mismatches = 0;
            probes     = 0;
            stores     = 0;
            hits       = 0;
        endfunction

        function void report(string what, longint want, longint got);
            mismatches++;
            if (mismatches <= 10)
                $display("[%0t] mismatch on %s: expected %0d, got %0d", $time, what, want, got);
        endfunction

        function int unsigned slot_of(logic [31:0] hash);
            int unsigned bits;
            bits = (idx_bits > TBITS) ? TBITS : idx_bits;
            return hash & ((32'd1 << bits) - 32'd1);
        endfunction

        function void note_request(tt_req_t r);
            tt_answer_t  a;
            int unsigned s;
            entry_t      e;
            a.hit   = 1'b0;
            a.score = '0;
            s = slot_of(r.hash);
            if (r.kind == REQ_STORE)
                stores++;
            else
                probes++;
            if (enable && r.kind == REQ_STORE)
            begin
                e.valid = 1'b1;
                e.key   = r.key;
                e.depth = r.depth;
                e.flags = r.flags;
                e.score = r.score;
                slot_mem[s] = e;
            end
            else if (enable && slot_mem.exists(s))
            begin
                e = slot_mem[s];
                if (e.key == r.key && e.depth >= r.depth
                    && (e.flags[FLAG_ABOVE_BETA] || $signed(e.score) >= r.beta)
                    && (e.flags[FLAG_BELOW_ALPHA] || $signed(e.score) <= r.alpha))
                begin
                    a.hit   = 1'b1;
                    a.score = e.score;
                    hits++;
                end
            end
            awaited.push_back(a);
        endfunction

        function void check_answer(logic hit_in, logic signed [15:0] score_in);
            tt_answer_t a;
            if (awaited.size() == 0)
            begin
                report("result with nothing outstanding", -1, hit_in);
                return;
            end
            a = awaited.pop_front();
            if (hit_in !== a.hit)
                report("hit", a.hit, hit_in);
            if (score_in !== a.score)
                report("found_score", a.score, score_in);
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  in_valid;
    logic                  in_ready;
    logic                  req_type;
    logic [31:0]           index_hash;
    logic [31:0]           check_key;
    logic [7:0]            depth;
    logic signed [15:0]    alpha;
    logic signed [15:0]    beta;
    logic [1:0]            bound_flags;
    logic signed [15:0]    store_score;
    logic                  out_valid;
    logic                  out_ready;
    logic                  hit;
    logic signed [15:0]    found_score;

    tt_shadow_table sb;
    tt_req_t        stored_pool[$];
    bit             tx_gaps_on;
    bit             rx_stalls_on;
    int             settings_seen;

    transposition_table_probe_store i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req_type    (req_type),
        .index_hash  (index_hash),
        .check_key   (check_key),
        .depth       (depth),
        .alpha       (alpha),
        .beta        (beta),
        .bound_flags (bound_flags),
        .store_score (store_score),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .hit         (hit),
        .found_score (found_score)
    );

    always #6 clk = ~clk;

    function automatic int pick_gap();
        int unsigned p;
        p = $urandom_range(0, 99);
        if (p < 55)
            return 0;
        if (p < 85)
            return $urandom_range(1, 3);
        if (p < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Mostly stores followed by probes aimed at them, window shaped to hit, some broken.
    function automatic tt_req_t gen_random();
        tt_req_t     r;
        tt_req_t     base;
        int unsigned p;
        int          s;
        r.kind  = 1'($urandom_range(0, 1));
        r.hash  = $urandom;
        r.key   = $urandom;
        r.depth = 8'($urandom_range(0, 255));
        r.alpha = 16'($urandom);
        r.beta  = 16'($urandom);
        r.flags = 2'($urandom_range(0, 3));
        r.score = 16'($urandom);
        p = $urandom_range(0, 99);
        if (p < 35)
        begin
            r.kind = REQ_STORE;
            stored_pool.push_back(r);
            if (stored_pool.size() > 24)
                void'(stored_pool.pop_front());
        end
        else if (p < 85 && stored_pool.size() > 0)
        begin
            base   = stored_pool[$urandom_range(0, stored_pool.size() - 1)];
            r.kind = REQ_PROBE;
            r.hash = base.hash;
            r.key  = base.key;
            if (p < 78)
            begin
                s       = int'(base.score);
                r.depth = 8'($urandom_range(0, base.depth));
                r.alpha = 16'(s + int'($urandom_range(0, 32767 - s)));
                r.beta  = 16'(s - int'($urandom_range(0, s + 32768)));
                if ($urandom_range(0, 3) == 0)
                begin
                    case ($urandom_range(0, 2))
                        0: if (base.depth < 8'd255) r.depth = base.depth + 8'd1;
                        1: if (s > -32768) r.alpha = 16'(s - 1);
                        default: if (s < 32767) r.beta = 16'(s + 1);
                    endcase
                end
            end
            else if (p < 82)
                r.key = base.key ^ (32'd1 << $urandom_range(0, 31));
        end
        return r;
    endfunction

    task automatic send_item(input tt_req_t r);
        @(negedge clk);
        req_type    = r.kind;
        index_hash  = r.hash;
        check_key   = r.key;
        depth       = r.depth;
        alpha       = r.alpha;
        beta        = r.beta;
        bound_flags = r.flags;
        store_score = r.score;
        in_valid    = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_request(r);
    endtask

    task automatic inter_gap();
        int g;
        g = tx_gaps_on ? pick_gap() : 0;
        if (g > 0)
        begin
            @(negedge clk);
            in_valid = 1'b0;
            repeat (g - 1) @(negedge clk);
        end
    endtask

    task automatic directed_item(input logic kind, input logic [31:0] hash,
                                 input logic [31:0] key, input logic [7:0] dep,
                                 input int a, input int b, input logic [1:0] flg, input int sc);
        tt_req_t r;
        r.kind  = kind;
        r.hash  = hash;
        r.key   = key;
        r.depth = dep;
        r.alpha = 16'(a);
        r.beta  = 16'(b);
        r.flags = flg;
        r.score = 16'(sc);
        send_item(r);
        inter_gap();
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (sb.awaited.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write then read back one register.
    task automatic cfg_set(input logic reg_idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = CFG_ADDR_W'(4 * int'(reg_idx));
        pwdata  = val;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        penable = 1'b0;
        pwrite  = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== val)
            sb.report("register readback", val, prdata);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        if (reg_idx == REG_TABLE_ENABLE)
            sb.enable = val[0];
        else
            sb.idx_bits = val[INDEX_BITS_W-1:0];
    endtask

    task automatic run_phase(input logic en, input int bits, input int count,
                             input bit gaps, input bit stalls);
        drain();
        cfg_set(REG_TABLE_ENABLE, CFG_DATA_W'(en));
        cfg_set(REG_INDEX_BITS, CFG_DATA_W'(bits));
        settings_seen++;
        tx_gaps_on   = gaps;
        rx_stalls_on = stalls;
        repeat (count)
        begin
            send_item(gen_random());
            inter_gap();
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_answer(hit, found_score);
    end

    initial
    begin
        int stall_left;
        stall_left = 0;
        out_ready  = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                out_ready = 1'b0;
                stall_left--;
            end
            else
            begin
                out_ready = 1'b1;
                if (rx_stalls_on && $urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("Timed out with %0d results outstanding", sb.awaited.size());
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        sb            = new();
        clk           = 1'b0;
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        in_valid      = 1'b0;
        req_type      = REQ_PROBE;
        index_hash    = '0;
        check_key     = '0;
        depth         = '0;
        alpha         = '0;
        beta          = '0;
        bound_flags   = '0;
        store_score   = '0;
        tx_gaps_on    = 1'b1;
        rx_stalls_on  = 1'b1;
        settings_seen = 1;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        cfg_set(REG_TABLE_ENABLE, CFG_DATA_W'(1));
        cfg_set(REG_INDEX_BITS, CFG_DATA_W'(16));

        // unwritten slot, extremes, depth and window edges, flag bypass, slot aliasing
        directed_item(REQ_PROBE, 32'h0, 32'h0, 8'd0, 0, 0, 2'd0, 0);
        directed_item(REQ_STORE, 32'h0, 32'h0, 8'd0, 0, 0, 2'd0, 0);
        directed_item(REQ_PROBE, 32'h0, 32'h0, 8'd0, 0, 0, 2'd0, 0);
        directed_item(REQ_STORE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd255, 32767, -32768, 2'd3,
                      -32768);
        directed_item(REQ_PROBE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd255, -32768, 32767, 2'd0, 0);
        directed_item(REQ_PROBE, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 8'd0, -32768, 32767, 2'd0, 0);
        directed_item(REQ_STORE, 32'h1234_5678, 32'hA5A5_A5A5, 8'd10, 0, 0, 2'd0, 32767);
        directed_item(REQ_PROBE, 32'h1234_5678, 32'hA5A5_A5A5, 8'd11, 32767, 32767, 2'd0, 0);
        directed_item(REQ_PROBE, 32'h1234_5678, 32'hA5A5_A5A5, 8'd10, 32767, 32767, 2'd0, 0);
        directed_item(REQ_PROBE, 32'h1234_5678, 32'hA5A5_A5A5, 8'd10, 32766, -32768, 2'd0, 0);
        directed_item(REQ_PROBE, 32'h1234_5678, 32'hA5A5_A5A5, 8'd0, 32767, -32768, 2'd0, 0);
        directed_item(REQ_STORE, 32'h1234_5678, 32'hA5A5_A5A5, 8'd10, 0, 0, 2'd1, 100);
        directed_item(REQ_PROBE, 32'h1234_5678, 32'hA5A5_A5A5, 8'd10, -32768, 100, 2'd0, 0);
        directed_item(REQ_PROBE, 32'h1234_5678, 32'hA5A5_A5A5, 8'd10, -32768, 101, 2'd0, 0);
        directed_item(REQ_STORE, 32'h1234_5678, 32'hA5A5_A5A5, 8'd10, 0, 0, 2'd2, -100);
        directed_item(REQ_PROBE, 32'h1234_5678, 32'hA5A5_A5A5, 8'd10, -100, 32767, 2'd0, 0);
        directed_item(REQ_PROBE, 32'h1234_5678, 32'hA5A5_A5A5, 8'd10, -101, 32767, 2'd0, 0);
        directed_item(REQ_PROBE, 32'h1234_5678, 32'h5A5A_5A5A, 8'd10, -100, 32767, 2'd0, 0);
        directed_item(REQ_PROBE, 32'h1234_5678, 32'hA5A5_A5A5, 8'd10, -100, 32767, 2'd3,
                      -32768);
        directed_item(REQ_STORE, 32'hABCD_0005, 32'h0BAD_F00D, 8'd200, -32768, 32767, 2'd3,
                      1234);
        directed_item(REQ_PROBE, 32'h0000_0005, 32'h0BAD_F00D, 8'd200, 0, 0, 2'd0, 0);
        directed_item(REQ_PROBE, 32'h0001_0005, 32'h0BAD_F00D, 8'd201, 0, 0, 2'd0, 0);

        run_phase(1'b1, 16, 110, 1'b1, 1'b1);
        run_phase(1'b1, 16, 40, 1'b0, 1'b0);
        run_phase(1'b1, 4, 70, 1'b1, 1'b1);
        run_phase(1'b1, 0, 40, 1'b1, 1'b0);
        run_phase(1'b1, 31, 50, 1'b0, 1'b1);
        run_phase(1'b0, 16, 40, 1'b1, 1'b1);
        run_phase(1'b1, 16, 50, 1'b1, 1'b1);
        run_phase(1'b1, 1, 40, 1'b1, 1'b1);
        run_phase(1'b1, 17, 40, 1'b1, 1'b0);

        drain();
        repeat (8) @(posedge clk);
        $display("Ran %0d probes (%0d expected hits) and %0d stores under %0d table settings",
                 sb.probes, sb.hits, sb.stores, settings_seen);
        $display("%0d mismatches", sb.mismatches);
        if (sb.mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
